>>> rtl/core/frequency_to_note_quantizer_top_defines.svh
// assertion macros for the frequency to note quantizer
`ifndef FREQUENCY_TO_NOTE_QUANTIZER_TOP_DEFINES_SVH
`define FREQUENCY_TO_NOTE_QUANTIZER_TOP_DEFINES_SVH
`ifndef SYNTH
`define FNQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FNQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FNQ_ASSERT(lbl, prop, msg)
`define FNQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/core/fnq_pkg.sv
// shared types and constants of the frequency to note quantizer
package fnq_pkg;

	localparam int M_W = 31;
	localparam int P_W = 5;
	localparam int F_W = 24;
	localparam int RN_W = 7;
	localparam int NT_W = 11;
	localparam int T_W = 21;
	localparam int U_W = 20;
	localparam int QT_W = 10;

	localparam logic [F_W-1:0] REF_FREQ_RST = 24'd112640;
	localparam logic [RN_W-1:0] REF_NOTE_RST = 7'd69;

	localparam logic REG_REF_FREQ = 1'b0;
	localparam logic REG_REF_NOTE = 1'b1;

	localparam logic signed [NT_W-1:0] NOTE_LO = -11'sd140;
	localparam logic signed [NT_W-1:0] NOTE_HI = 11'sd160;
	localparam int TEN_BIAS = 289500;
	localparam int RECIP_1000 = 1073742;
	localparam int RECIP_12 = 171;

	typedef struct packed {
		logic fv;
		logic [RN_W-1:0] rn;
	} fnq_meta_t;

	typedef struct packed {
		logic [P_W-1:0] p;
		logic [M_W-1:0] m;
	} fnq_norm_t;

	function automatic fnq_norm_t fnq_normalize(input logic [F_W-1:0] v);
		logic [F_W-1:0] w;
		logic [P_W-1:0] p;
		fnq_norm_t r;
		w = (v == '0) ? F_W'(1) : v;
		p = '0;
		for (int i = 0; i < F_W; i++) begin
			if (w[i]) p = P_W'(i);
		end
		r.p = p;
		r.m = M_W'(w) << (P_W'(30) - p);
		return r;
	endfunction

endpackage

>>> rtl/core/fnq_log_cell.sv
// one squaring step of the log2 chain for the frequency and reference lanes
module fnq_log_cell import fnq_pkg::*; #(
	parameter int R_W = 21
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  logic [M_W-1:0] up_mf,
	input  logic [R_W-1:0] up_rf,
	input  logic [M_W-1:0] up_mr,
	input  logic [R_W-1:0] up_rr,
	input  fnq_meta_t      up_meta,
	output logic           dn_valid,
	input  logic           dn_ready,
	output logic [M_W-1:0] dn_mf,
	output logic [R_W-1:0] dn_rf,
	output logic [M_W-1:0] dn_mr,
	output logic [R_W-1:0] dn_rr,
	output fnq_meta_t      dn_meta
);

	logic valid_q;
	logic [2*M_W-1:0] prod_f, prod_r;
	logic [M_W:0] sq_f, sq_r;
	logic [M_W-1:0] mf_n, mr_n;
	logic [R_W-1:0] rf_n, rr_n;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;

	always_comb begin
		prod_f = (2*M_W)'(up_mf) * (2*M_W)'(up_mf);
		prod_r = (2*M_W)'(up_mr) * (2*M_W)'(up_mr);
		sq_f = prod_f[2*M_W-1:30];
		sq_r = prod_r[2*M_W-1:30];
		mf_n = sq_f[M_W] ? sq_f[M_W:1] : sq_f[M_W-1:0];
		mr_n = sq_r[M_W] ? sq_r[M_W:1] : sq_r[M_W-1:0];
		rf_n = {up_rf[R_W-2:0], sq_f[M_W]};
		rr_n = {up_rr[R_W-2:0], sq_r[M_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			dn_mf <= mf_n;
			dn_mr <= mr_n;
			dn_rf <= rf_n;
			dn_rr <= rr_n;
			dn_meta <= up_meta;
		end
	end

endmodule

>>> rtl/core/fnq_post.sv
// scaling, rounding, saturation, wrap and note split after the log2 chain
module fnq_post import fnq_pkg::*; #(
	parameter int L = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	output logic                   up_ready,
	input  logic [P_W+L-1:0]       up_rf,
	input  logic [P_W+L-1:0]       up_rr,
	input  fnq_meta_t              up_meta,
	output logic                   dn_valid,
	input  logic                   dn_stall,
	output logic                   freq_valid,
	output logic signed [8:0]      midi_number,
	output logic                   name_valid,
	output logic [3:0]             pitch_class,
	output logic signed [4:0]      octave,
	output logic signed [9:0]      cents_tenths
);

	localparam int R_W = P_W + L;
	localparam int D_W = R_W + 1;
	localparam int S_W = D_W + 5;
	localparam int K_W = D_W + 15;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [S_W-1:0] s12_s1;
	logic signed [K_W-1:0] sk_s1;
	logic fv_s1;

	logic signed [NT_W-1:0] note_s2;
	logic signed [T_W-1:0] ten_s2;
	logic fv_s2;

	logic signed [8:0] ns_s3;
	logic named_s3;
	logic [3:0] q12_s3;
	logic [U_W-1:0] u_s3;
	logic [QT_W-1:0] qt_s3;
	logic fv_s3;

	logic signed [D_W-1:0] d;
	logic [S_W-1:0] a12, q12u;
	logic [K_W-1:0] ak, qku;
	logic signed [NT_W-1:0] qn, note_n;
	logic signed [T_W-1:0] qt_n, ten_n;
	logic signed [NT_W-1:0] sat;
	logic signed [T_W:0] ue;
	logic [U_W+21:0] pt;
	logic [15:0] pq;
	logic [U_W-1:0] rem;
	logic [7:0] idx8;

	assign en4 = !v_s4 || !dn_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign up_ready = en1;
	assign dn_valid = v_s4;

	always_comb begin
		d = $signed({1'b0, up_rf}) - $signed({1'b0, up_rr});

		a12 = s12_s1[S_W-1] ? S_W'(-s12_s1) : S_W'(s12_s1);
		q12u = (a12 + (S_W'(1) << (L-1))) >> L;
		qn = $signed(q12u[NT_W-1:0]);
		note_n = s12_s1[S_W-1] ? -qn : qn;

		ak = sk_s1[K_W-1] ? K_W'(-sk_s1) : K_W'(sk_s1);
		qku = (ak + (K_W'(1) << (L-1))) >> L;
		qt_n = $signed(qku[T_W-1:0]);
		ten_n = sk_s1[K_W-1] ? -qt_n : qt_n;

		if (note_s2 < NOTE_LO) sat = NOTE_LO;
		else if (note_s2 > NOTE_HI) sat = NOTE_HI;
		else sat = note_s2;
		ue = {ten_s2[T_W-1], ten_s2} + (T_W+1)'(TEN_BIAS);
		pt = (U_W+22)'(ue[U_W-1:0]) * (U_W+22)'(RECIP_1000);
		pq = 16'(sat[7:0]) * 16'(RECIP_12);

		rem = u_s3 - U_W'(qt_s3) * U_W'(1000);
		idx8 = 8'(ns_s3) - 8'(q12_s3) * 8'd12;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= up_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && up_valid) begin
			s12_s1 <= S_W'(d) * S_W'(12) + $signed(S_W'(up_meta.rn) << L);
			sk_s1 <= K_W'(d) * K_W'(12000);
			fv_s1 <= up_meta.fv;
		end
		if (en2 && v_s1) begin
			note_s2 <= note_n;
			ten_s2 <= ten_n;
			fv_s2 <= fv_s1;
		end
		if (en3 && v_s2) begin
			ns_s3 <= 9'(sat);
			named_s3 <= !sat[NT_W-1];
			q12_s3 <= 4'(pq >> 11);
			u_s3 <= ue[U_W-1:0];
			qt_s3 <= QT_W'(pt >> 30);
			fv_s3 <= fv_s2;
		end
		if (en4 && v_s3) begin
			freq_valid <= fv_s3;
			if (!fv_s3) begin
				midi_number <= -9'sd1;
				name_valid <= 1'b0;
				pitch_class <= '0;
				octave <= '0;
				cents_tenths <= '0;
			end else begin
				midi_number <= ns_s3;
				name_valid <= named_s3;
				pitch_class <= named_s3 ? idx8[3:0] : 4'd0;
				octave <= named_s3 ? $signed(5'(q12_s3) - 5'd1) : 5'sd0;
				cents_tenths <= $signed(10'(rem) - 10'd500);
			end
		end
	end

endmodule

>>> rtl/core/frequency_to_note_quantizer_top.sv
// top level of the frequency to note quantizer
//  channel | signals                                   | transaction when
//  req     | req_valid, req_stall, frequency           | req_valid && !req_stall
//  rsp     | rsp_valid, rsp_stall, result fields       | rsp_valid && !rsp_stall
//  cfg     | wr_en, wr_index, wr_data                  | wr_en
// one frequency per cycle while req_stall is low; stages are normalize, one
// squaring cell per fraction bit, four post stages
// each stage holds its own valid, so bubbles close up under rsp_stall
// reset clears stage valids and restores 440 Hz / note 69
module frequency_to_note_quantizer_top import fnq_pkg::*; #(
	parameter int LOG_FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [F_W-1:0]    wr_data,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [F_W-1:0]    frequency,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              freq_valid,
	output logic signed [8:0] midi_number,
	output logic              name_valid,
	output logic [3:0]        pitch_class,
	output logic signed [4:0] octave,
	output logic signed [9:0] cents_tenths
);

`include "frequency_to_note_quantizer_top_defines.svh"

	localparam int L = LOG_FRAC_BITS;
	localparam int R_W = P_W + L;

	logic [F_W-1:0] ref_freq_q;
	logic [RN_W-1:0] ref_note_q;

	logic v_s0, en0;
	fnq_norm_t nf, nr;
	logic [M_W-1:0] mf_s0, mr_s0;
	logic [R_W-1:0] rf_s0, rr_s0;
	fnq_meta_t      meta_s0;

	logic           c_valid [L+1];
	logic           c_ready [L+1];
	logic [M_W-1:0] c_mf [L+1];
	logic [R_W-1:0] c_rf [L+1];
	logic [M_W-1:0] c_mr [L+1];
	logic [R_W-1:0] c_rr [L+1];
	fnq_meta_t      c_meta [L+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_freq_q <= REF_FREQ_RST;
			ref_note_q <= REF_NOTE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_REF_FREQ: ref_freq_q <= wr_data;
				REG_REF_NOTE: ref_note_q <= wr_data[RN_W-1:0];
				default: ;
			endcase
		end
	end

	assign en0 = !v_s0 || c_ready[0];
	assign req_stall = !en0;
	assign nf = fnq_normalize(frequency);
	assign nr = fnq_normalize(ref_freq_q);
	assign c_valid[0] = v_s0;
	assign c_mf[0] = mf_s0;
	assign c_rf[0] = rf_s0;
	assign c_mr[0] = mr_s0;
	assign c_rr[0] = rr_s0;
	assign c_meta[0] = meta_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en0) begin
			v_s0 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en0 && req_valid) begin
			mf_s0 <= nf.m;
			rf_s0 <= R_W'(nf.p);
			mr_s0 <= nr.m;
			rr_s0 <= R_W'(nr.p);
			meta_s0.fv <= (frequency != '0);
			meta_s0.rn <= ref_note_q;
		end
	end

	for (genvar i = 0; i < L; i++) begin : g_cell
		fnq_log_cell #(.R_W(R_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (c_valid[i]),
			.up_ready (c_ready[i]),
			.up_mf    (c_mf[i]),
			.up_rf    (c_rf[i]),
			.up_mr    (c_mr[i]),
			.up_rr    (c_rr[i]),
			.up_meta  (c_meta[i]),
			.dn_valid (c_valid[i+1]),
			.dn_ready (c_ready[i+1]),
			.dn_mf    (c_mf[i+1]),
			.dn_rf    (c_rf[i+1]),
			.dn_mr    (c_mr[i+1]),
			.dn_rr    (c_rr[i+1]),
			.dn_meta  (c_meta[i+1])
		);
	end

	fnq_post #(.L(L)) u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (c_valid[L]),
		.up_ready     (c_ready[L]),
		.up_rf        (c_rf[L]),
		.up_rr        (c_rr[L]),
		.up_meta      (c_meta[L]),
		.dn_valid     (rsp_valid),
		.dn_stall     (rsp_stall),
		.freq_valid   (freq_valid),
		.midi_number  (midi_number),
		.name_valid   (name_valid),
		.pitch_class  (pitch_class),
		.octave       (octave),
		.cents_tenths (cents_tenths)
	);

	`FNQ_ASSERT(a_invalid_result, rsp_valid && !freq_valid |-> midi_number == -9'sd1 && cents_tenths == 10'sd0 && !name_valid, "invalid frequency result malformed")
	`FNQ_ASSERT(a_name_fields, rsp_valid && name_valid |-> pitch_class < 4'd12 && octave <= 5'sd12 && !midi_number[8], "note name fields out of range")
	`FNQ_ASSERT(a_cents_range, rsp_valid |-> cents_tenths >= -10'sd500 && cents_tenths <= 10'sd499, "cents offset out of range")
	`FNQ_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !rsp_valid || $past(!arst_n, 1) == 1'b0, "pipeline not empty after reset")

endmodule
